// File: design/sera_pkg.sv
// shared constants, angle table and helpers for the rejection angle pipeline
package sera_pkg;

	localparam int ANG_W        = 34;
	localparam int XW           = 45;
	localparam int CORDIC_STEPS = 30;
	localparam int NORM_EXP     = 40;
	localparam int ISQRT_STEPS  = 32;
	localparam int MOD_STEPS    = 32;

	localparam logic signed [ANG_W-1:0] ANG_HALF_PI  = 34'sd843314857;
	localparam logic signed [ANG_W-1:0] ANG_PI       = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] ANG_3HALF_PI = 34'sd2529944570;
	localparam logic signed [ANG_W-1:0] ANG_2PI      = 34'sd3373259426;

	localparam logic [31:0] ATAN_TAB [10] = '{
		32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843,
		32'd16771758, 32'd8387925, 32'd4194219, 32'd2097141, 32'd1048575
	};

	// atan(2^-i) in Q3.29, exact power of two once the table runs out
	function automatic logic [31:0] step_angle(input logic [4:0] idx);
		if (idx < 5'd10) begin
			return ATAN_TAB[idx[3:0]];
		end
		return 32'd1 << (5'd29 - idx);
	endfunction

endpackage

// File: design/sera_in_if.sv
// input channel: coefficients, budget and direction
interface sera_in_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] a_coef;
	logic signed [31:0] b_coef;
	logic [31:0]       gamma_budget;
	logic              direction_negative;

	modport source (output valid, a_coef, b_coef, gamma_budget, direction_negative,
		input ready);
	modport sink (input valid, a_coef, b_coef, gamma_budget, direction_negative,
		output ready);
endinterface

// File: design/sera_out_if.sv
// output channel: rejection angle and zero magnitude flag
interface sera_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] reject_angle;
	logic        zero_magnitude;

	modport source (output valid, reject_angle, zero_magnitude, input ready);
	modport sink (input valid, reject_angle, zero_magnitude, output ready);
endinterface

// File: design/sera_isqrt.sv
// pipelined 64 bit integer square root, one result bit per stage
module sera_isqrt import sera_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [63:0]   val,
	input  logic [SW-1:0] side_i,
	output logic          vout,
	output logic [31:0]   root,
	output logic [SW-1:0] side_o
);

	logic          vl_s [0:ISQRT_STEPS];
	logic [63:0]   v_s  [0:ISQRT_STEPS];
	logic [63:0]   r_s  [0:ISQRT_STEPS];
	logic [SW-1:0] sd_s [0:ISQRT_STEPS];

	assign vl_s[0] = vin;
	assign v_s[0]  = val;
	assign r_s[0]  = '0;
	assign sd_s[0] = side_i;

	for (genvar i = 0; i < ISQRT_STEPS; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial, nv, nr;

		always_comb begin
			trial = r_s[i] + BIT;
			if (v_s[i] >= trial) begin
				nv = v_s[i] - trial;
				nr = (r_s[i] >> 1) + BIT;
			end else begin
				nv = v_s[i];
				nr = r_s[i] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[i+1] <= 1'b0;
			end else if (en) begin
				vl_s[i+1] <= vl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i+1]  <= nv;
				r_s[i+1]  <= nr;
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign vout   = vl_s[ISQRT_STEPS];
	assign root   = r_s[ISQRT_STEPS][31:0];
	assign side_o = sd_s[ISQRT_STEPS];

endmodule

// File: design/sera_mod.sv
// pipelined remainder of a 32 bit value by a 33 bit divisor, one bit per stage
module sera_mod import sera_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [31:0]   num,
	input  logic [32:0]   den,
	input  logic [SW-1:0] side_i,
	output logic          vout,
	output logic [32:0]   rem,
	output logic [SW-1:0] side_o
);

	logic          vl_s [0:MOD_STEPS];
	logic [31:0]   n_s  [0:MOD_STEPS];
	logic [32:0]   d_s  [0:MOD_STEPS];
	logic [33:0]   r_s  [0:MOD_STEPS];
	logic [SW-1:0] sd_s [0:MOD_STEPS];

	assign vl_s[0] = vin;
	assign n_s[0]  = num;
	assign d_s[0]  = den;
	assign r_s[0]  = '0;
	assign sd_s[0] = side_i;

	for (genvar i = 0; i < MOD_STEPS; i++) begin : g_step
		logic [33:0] sh, nr;

		always_comb begin
			sh = {r_s[i][32:0], n_s[i][MOD_STEPS-1-i]};
			if (sh >= {1'b0, d_s[i]}) begin
				nr = sh - {1'b0, d_s[i]};
			end else begin
				nr = sh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[i+1] <= 1'b0;
			end else if (en) begin
				vl_s[i+1] <= vl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1]  <= n_s[i];
				d_s[i+1]  <= d_s[i];
				r_s[i+1]  <= nr;
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign vout   = vl_s[MOD_STEPS];
	assign rem    = r_s[MOD_STEPS][32:0];
	assign side_o = sd_s[MOD_STEPS];

endmodule

// File: design/sera_cordic.sv
// pipelined vectoring cordic: normalise, quarter turn, then one micro-rotation per stage
module sera_cordic import sera_pkg::*; #(
	parameter int SW = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vin,
	input  logic signed [32:0]      y_in,
	input  logic signed [32:0]      x_in,
	input  logic [SW-1:0]           side_i,
	output logic                    vout,
	output logic signed [ANG_W-1:0] angle,
	output logic [SW-1:0]           side_o
);

	function automatic logic [5:0] lead_pos(input logic [33:0] v);
		logic [5:0] p;
		p = '0;
		for (int j = 0; j < 34; j++) begin
			if (v[j]) begin
				p = 6'(j);
			end
		end
		return p;
	endfunction

	logic [33:0] my, mx, mor;

	logic                    vld_s1, vld_s2, vld_s3;
	logic signed [32:0]      y_s1, x_s1;
	logic [5:0]              k_s1;
	logic                    zr_s1, zr_s2, zr_s3;
	logic signed [XW-1:0]    y_s2, x_s2, y_s3, x_s3;
	logic signed [ANG_W-1:0] z_s3;
	logic [SW-1:0]           sd_s1, sd_s2, sd_s3;

	logic                    vl_s [0:CORDIC_STEPS];
	logic signed [XW-1:0]    cx_s [0:CORDIC_STEPS];
	logic signed [XW-1:0]    cy_s [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cz_s [0:CORDIC_STEPS];
	logic                    zf_s [0:CORDIC_STEPS];
	logic [SW-1:0]           sd_s [0:CORDIC_STEPS];

	always_comb begin
		my  = y_in[32] ? 34'(-35'(y_in)) : 34'(y_in);
		mx  = x_in[32] ? 34'(-35'(x_in)) : 34'(x_in);
		mor = my | mx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vin;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// shift that brings the larger magnitude into [2^40, 2^41)
			y_s1  <= y_in;
			x_s1  <= x_in;
			k_s1  <= 6'(NORM_EXP) - lead_pos(mor);
			zr_s1 <= (mor == '0);
			sd_s1 <= side_i;

			y_s2  <= XW'(y_s1) <<< k_s1;
			x_s2  <= XW'(x_s1) <<< k_s1;
			zr_s2 <= zr_s1;
			sd_s2 <= sd_s1;

			if (x_s2 < 0) begin
				if (y_s2 >= 0) begin
					x_s3 <= y_s2;
					y_s3 <= -x_s2;
					z_s3 <= ANG_HALF_PI;
				end else begin
					x_s3 <= -y_s2;
					y_s3 <= x_s2;
					z_s3 <= -ANG_HALF_PI;
				end
			end else begin
				x_s3 <= x_s2;
				y_s3 <= y_s2;
				z_s3 <= '0;
			end
			zr_s3 <= zr_s2;
			sd_s3 <= sd_s2;
		end
	end

	assign vl_s[0] = vld_s3;
	assign cx_s[0] = x_s3;
	assign cy_s[0] = y_s3;
	assign cz_s[0] = z_s3;
	assign zf_s[0] = zr_s3;
	assign sd_s[0] = sd_s3;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [ANG_W-1:0] STEP_A = ANG_W'(step_angle(5'(i)));
		logic signed [XW-1:0]    dx, dy, nx, ny;
		logic signed [ANG_W-1:0] nz;

		always_comb begin
			dx = cy_s[i] >>> i;
			dy = cx_s[i] >>> i;
			if (cy_s[i] > 0) begin
				nx = cx_s[i] + dx;
				ny = cy_s[i] - dy;
				nz = cz_s[i] + STEP_A;
			end else begin
				nx = cx_s[i] - dx;
				ny = cy_s[i] + dy;
				nz = cz_s[i] - STEP_A;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s[i+1] <= 1'b0;
			end else if (en) begin
				vl_s[i+1] <= vl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[i+1] <= nx;
				cy_s[i+1] <= ny;
				cz_s[i+1] <= nz;
				zf_s[i+1] <= zf_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign vout   = vl_s[CORDIC_STEPS];
	assign angle  = zf_s[CORDIC_STEPS] ? '0 : cz_s[CORDIC_STEPS];
	assign side_o = sd_s[CORDIC_STEPS];

endmodule

// File: design/sinusoidal_event_reject_angle.sv
// top level: rejection angle of a sinusoidal event rate, fully pipelined
// Takes one transaction per clock and returns one result per transaction, in order.
// Each transaction passes through the chain of two 32-stage square roots, two 33-stage
// cordic units, the 32-stage remainder unit and eleven glue stages. A stall on the output
// freezes the whole pipeline; input ready is low only while a finished result waits in
// the output register and is not being taken.
module sinusoidal_event_reject_angle import sera_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	sera_in_if.sink    in_ch,
	sera_out_if.source out_ch
);

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [32:0] bn;
		logic [31:0]        g;
	} sd1_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic [31:0]        g;
		logic [31:0]        rr;
	} sd2_t;

	typedef struct packed {
		logic signed [31:0]      a;
		logic [31:0]             rr;
		logic signed [ANG_W-1:0] phi;
		logic                    zero;
	} sd3_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] phi;
		logic                    split;
		logic                    upper;
		logic                    zero;
		logic signed [32:0]      num;
	} sd4_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] phi;
		logic                    split;
		logic                    upper;
		logic                    zero;
	} sd5_t;

	localparam logic signed [35:0] HALF36  = 36'(ANG_HALF_PI);
	localparam logic signed [35:0] PI36    = 36'(ANG_PI);
	localparam logic signed [35:0] THREE36 = 36'(ANG_3HALF_PI);
	localparam logic signed [35:0] TURN36  = 36'(ANG_2PI);

	logic en;

	// front: negate, magnitudes, squares, sum
	logic                vld_s1, vld_s2, vld_s3;
	logic signed [31:0]  a_s1;
	logic signed [32:0]  bn_s1;
	logic [31:0]         g_s1, am_s1, bm_s1;
	logic [63:0]         asq_s2, bsq_s2, sum_s3;
	sd1_t                sd_s2, sd_s3;
	logic signed [32:0]  bn_in;

	// first square root and phase
	logic                    v1o, v2o;
	logic [31:0]             rr1;
	sd1_t                    sd1o;
	sd2_t                    sd2i, sd2o;
	logic signed [ANG_W-1:0] phi_raw;

	// remainder and arcsine argument
	logic                    vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, v3o;
	logic signed [ANG_W-1:0] phi_s4;
	logic [32:0]             d_s4;
	logic [31:0]             g_s4;
	sd3_t                    sd_s4, sd3o;
	logic [32:0]             gr;
	logic signed [35:0]      gr36, a36, rr36, p1, num36;
	logic                    split_c, upper_c;
	logic signed [35:0]      num_s5;
	sd5_t                    fl_s5, fl_s6, fl_s7, fl_s8;
	logic [31:0]             rr_s5, rr_s6;
	logic signed [32:0]      num_s6, num_s7, num_s8;
	logic [63:0]             rsq_s7, nsq_s7, diff_s8;
	logic [31:0]             nmag;

	// second square root and arcsine
	logic                    v4o, v5o;
	logic [31:0]             croot;
	sd4_t                    sd4i, sd4o;
	sd5_t                    sd5o;
	logic signed [ANG_W-1:0] as_ang;

	// angle assembly
	logic                    vld_s9, vld_s10, vld_s11;
	logic signed [35:0]      th1_s9, th2_s9, lo_s9, hi_s9;
	logic signed [35:0]      th1_s10, th2_s10, lo_s10, hi_s10;
	logic                    zr_s9, zr_s10;
	logic signed [35:0]      phi36, as36, lo_c, hi_c;
	logic [31:0]             ang_s11;
	logic                    zm_s11;

	assign en          = !vld_s11 || out_ch.ready;
	assign in_ch.ready = en;

	assign bn_in = in_ch.direction_negative ? -33'(in_ch.b_coef) : 33'(in_ch.b_coef);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_ch.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= v2o;
			vld_s5  <= v3o;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= v5o;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= in_ch.a_coef;
			bn_s1  <= bn_in;
			g_s1   <= in_ch.gamma_budget;
			am_s1  <= 32'(in_ch.a_coef[31] ? -33'(in_ch.a_coef) : 33'(in_ch.a_coef));
			bm_s1  <= 32'(bn_in[32] ? -bn_in : bn_in);

			asq_s2 <= 64'(am_s1) * 64'(am_s1);
			bsq_s2 <= 64'(bm_s1) * 64'(bm_s1);
			sd_s2  <= '{a: a_s1, bn: bn_s1, g: g_s1};

			sum_s3 <= asq_s2 + bsq_s2;
			sd_s3  <= sd_s2;
		end
	end

	sera_isqrt #(.SW($bits(sd1_t))) u_isqrt_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (vld_s3),
		.val    (sum_s3),
		.side_i (sd_s3),
		.vout   (v1o),
		.root   (rr1),
		.side_o (sd1o)
	);

	assign sd2i = '{a: sd1o.a, g: sd1o.g, rr: rr1};

	sera_cordic #(.SW($bits(sd2_t))) u_cordic_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v1o),
		.y_in   (-33'(sd1o.a)),
		.x_in   (sd1o.bn),
		.side_i (sd2i),
		.vout   (v2o),
		.angle  (phi_raw),
		.side_o (sd2o)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (phi_raw < 0) begin
				phi_s4 <= phi_raw + ANG_2PI;
			end else if (phi_raw >= ANG_2PI) begin
				phi_s4 <= phi_raw - ANG_2PI;
			end else begin
				phi_s4 <= phi_raw;
			end
			d_s4  <= {sd2o.rr, 1'b0};
			g_s4  <= sd2o.g;
			sd_s4 <= '{a: sd2o.a, rr: sd2o.rr, phi: '0, zero: (sd2o.rr == '0)};
		end
	end

	sera_mod #(.SW($bits(sd3_t))) u_mod_period (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (vld_s4),
		.num    (g_s4),
		.den    (d_s4),
		.side_i (sd3_t'{a: sd_s4.a, rr: sd_s4.rr, phi: phi_s4, zero: sd_s4.zero}),
		.vout   (v3o),
		.rem    (gr),
		.side_o (sd3o)
	);

	// layout and unclamped arcsine numerator
	always_comb begin
		gr36    = $signed({3'b000, gr});
		a36     = 36'(sd3o.a);
		rr36    = $signed({4'b0000, sd3o.rr});
		p1      = rr36 - a36;
		split_c = (sd3o.phi < ANG_HALF_PI) || (sd3o.phi > ANG_3HALF_PI);
		upper_c = split_c && (gr36 > p1);
		if (!split_c) begin
			num36 = gr36 - rr36;
		end else if (upper_c) begin
			num36 = gr36 - p1 - rr36;
		end else begin
			num36 = gr36 + a36;
		end
	end

	assign nmag = 32'(num_s6[32] ? -num_s6 : num_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= num36;
			rr_s5  <= sd3o.rr;
			fl_s5  <= '{phi: sd3o.phi, split: split_c, upper: upper_c, zero: sd3o.zero};

			if (num_s5 > $signed({4'b0000, rr_s5})) begin
				num_s6 <= $signed({1'b0, rr_s5});
			end else if (num_s5 < -$signed({4'b0000, rr_s5})) begin
				num_s6 <= -$signed({1'b0, rr_s5});
			end else begin
				num_s6 <= 33'(num_s5);
			end
			rr_s6 <= rr_s5;
			fl_s6 <= fl_s5;

			rsq_s7 <= 64'(rr_s6) * 64'(rr_s6);
			nsq_s7 <= 64'(nmag) * 64'(nmag);
			num_s7 <= num_s6;
			fl_s7  <= fl_s6;

			diff_s8 <= rsq_s7 - nsq_s7;
			num_s8  <= num_s7;
			fl_s8   <= fl_s7;
		end
	end

	assign sd4i = '{phi: fl_s8.phi, split: fl_s8.split, upper: fl_s8.upper,
		zero: fl_s8.zero, num: num_s8};

	sera_isqrt #(.SW($bits(sd4_t))) u_isqrt_cos (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (vld_s8),
		.val    (diff_s8),
		.side_i (sd4i),
		.vout   (v4o),
		.root   (croot),
		.side_o (sd4o)
	);

	sera_cordic #(.SW($bits(sd5_t))) u_cordic_asin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (v4o),
		.y_in   (sd4o.num),
		.x_in   ($signed({1'b0, croot})),
		.side_i (sd5_t'{phi: sd4o.phi, split: sd4o.split, upper: sd4o.upper,
			zero: sd4o.zero}),
		.vout   (v5o),
		.angle  (as_ang),
		.side_o (sd5o)
	);

	// active interval of the chosen layout
	always_comb begin
		phi36 = 36'(sd5o.phi);
		as36  = 36'(as_ang);
		if (!sd5o.split) begin
			lo_c = phi36 - HALF36;
			hi_c = phi36 + HALF36;
		end else if (sd5o.phi < ANG_HALF_PI) begin
			if (sd5o.upper) begin
				lo_c = THREE36 + phi36;
				hi_c = TURN36;
			end else begin
				lo_c = '0;
				hi_c = HALF36 + phi36;
			end
		end else begin
			if (sd5o.upper) begin
				lo_c = phi36 - HALF36;
				hi_c = TURN36;
			end else begin
				lo_c = '0;
				hi_c = phi36 - THREE36;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th1_s9 <= phi36 + as36 + TURN36;
			th2_s9 <= phi36 + PI36 - as36 + TURN36;
			lo_s9  <= lo_c;
			hi_s9  <= hi_c;
			zr_s9  <= sd5o.zero;

			// both sums are non-negative and below three turns
			if (th1_s9 >= (TURN36 <<< 1)) begin
				th1_s10 <= th1_s9 - (TURN36 <<< 1);
			end else if (th1_s9 >= TURN36) begin
				th1_s10 <= th1_s9 - TURN36;
			end else begin
				th1_s10 <= th1_s9;
			end
			if (th2_s9 >= (TURN36 <<< 1)) begin
				th2_s10 <= th2_s9 - (TURN36 <<< 1);
			end else if (th2_s9 >= TURN36) begin
				th2_s10 <= th2_s9 - TURN36;
			end else begin
				th2_s10 <= th2_s9;
			end
			lo_s10 <= lo_s9;
			hi_s10 <= hi_s9;
			zr_s10 <= zr_s9;

			if (zr_s10) begin
				ang_s11 <= '0;
			end else if (th1_s10 < hi_s10 && th1_s10 > lo_s10) begin
				ang_s11 <= th1_s10[31:0];
			end else begin
				ang_s11 <= th2_s10[31:0];
			end
			zm_s11 <= zr_s10;
		end
	end

	assign out_ch.valid          = vld_s11;
	assign out_ch.reject_angle   = ang_s11;
	assign out_ch.zero_magnitude = zm_s11;

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.zero_magnitude) |-> (out_ch.reject_angle == 32'd0))
		else $error("zero magnitude result with nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.reject_angle < 32'd3373259426))
		else $error("rejection angle outside one turn");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v4o) && $stable(vld_s4)))
		else $error("pipeline moved during a stall");

endmodule

// File: tb/sv/tb_sinusoidal_event_reject_angle.sv
// testbench for the rejection angle pipeline: driver, monitor and bit-true predictor
module tb_sinusoidal_event_reject_angle;
	timeunit 1ns;
	timeprecision 1ps;
	import sera_pkg::*;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] g;
		logic        neg;
	} coef_item_t;

	typedef struct packed {
		logic [31:0] angle;
		logic        zero;
	} angle_res_t;

	localparam longint PH_HALF  = 64'sd843314857;
	localparam longint PH_PI    = 64'sd1686629713;
	localparam longint PH_3HALF = 64'sd2529944570;
	localparam longint PH_TURN  = 64'sd3373259426;
	localparam int LATENCY = 173;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	sera_in_if in_ch();
	sera_out_if out_ch();

	sinusoidal_event_reject_angle u_dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch));

	coef_item_t pending_q[$];
	angle_res_t angle_q[$];
	int mismatches = 0;
	longint cycles = 0;
	bit hold_rx;
	bit in_taken;
	int tx_gap;
	int rx_gap;

	function automatic longint floor_shift(longint v, int s);
		longint m;
		if (v >= 0) begin
			return v >>> s;
		end
		m = -v;
		return -((m + ((64'sd1 << s) - 1)) >>> s);
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) begin
			bitv >>= 2;
		end
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint vector_phase(longint y, longint x);
		longint z;
		longint t;
		longint dx;
		longint dy;
		longint stp;
		z = 0;
		if (x == 0 && y == 0) begin
			return 0;
		end
		while (abs64(x) < (64'sd1 << 40) && abs64(y) < (64'sd1 << 40)) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = PH_HALF;
			end else begin
				x = -y; y = t; z = -PH_HALF;
			end
		end
		for (int i = 0; i < 30; i++) begin
			// own arctangent table, pure powers of two past step nine
			case (i)
				0: stp = 421657428;
				1: stp = 248918915;
				2: stp = 131521918;
				3: stp = 66762579;
				4: stp = 33510843;
				5: stp = 16771758;
				6: stp = 8387925;
				7: stp = 4194219;
				8: stp = 2097141;
				9: stp = 1048575;
				default: stp = 64'sd1 << (29 - i);
			endcase
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += stp;
			end else begin
				x -= dx; y += dy; z -= stp;
			end
		end
		return z;
	endfunction

	function automatic longint wrap_phase(longint v);
		longint r;
		r = v % PH_TURN;
		if (r < 0) begin
			r += PH_TURN;
		end
		return r;
	endfunction

	function automatic angle_res_t predict_angle(coef_item_t it);
		angle_res_t r;
		longint a, b, g, rr, phi, gr, num, p1, asn, th1, th2, lo, hi;
		longint unsigned sq, c;
		bit split, upper;
		a = longint'(signed'(it.a));
		b = longint'(signed'(it.b));
		g = longint'({32'd0, it.g});
		upper = 0;
		if (it.neg) begin
			b = -b;
		end
		sq = longint'(a * a) + longint'(b * b);
		rr = int_sqrt(sq);
		if (rr == 0) begin
			r.angle = '0;
			r.zero = 1;
			return r;
		end
		phi = vector_phase(-a, b);
		if (phi < 0) begin
			phi += PH_TURN;
		end
		if (phi >= PH_TURN) begin
			phi -= PH_TURN;
		end
		gr = g % (2 * rr);
		split = (phi < PH_HALF) || (phi > PH_3HALF);
		if (split) begin
			p1 = rr - a;
			if (gr > p1) begin
				upper = 1;
				num = gr - p1 - rr;
			end else begin
				num = gr + a;
			end
		end else begin
			num = gr - rr;
		end
		if (num > rr) begin
			num = rr;
		end
		if (num < -rr) begin
			num = -rr;
		end
		c = int_sqrt(rr * rr - num * num);
		asn = vector_phase(num, longint'(c));
		th1 = wrap_phase(phi + asn + PH_TURN);
		th2 = wrap_phase(phi + PH_PI - asn + PH_TURN);
		if (!split) begin
			lo = phi - PH_HALF;
			hi = phi + PH_HALF;
		end else if (phi < PH_HALF) begin
			if (upper) begin
				lo = PH_3HALF + phi; hi = PH_TURN;
			end else begin
				lo = 0; hi = PH_HALF + phi;
			end
		end else begin
			if (upper) begin
				lo = phi - PH_HALF; hi = PH_TURN;
			end else begin
				lo = 0; hi = phi - PH_3HALF;
			end
		end
		r.angle = 32'((th1 < hi && th1 > lo) ? th1 : th2);
		r.zero = 0;
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 2) == 0) begin
			return 0;
		end
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 16) - 8;
			3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_budget();
		case ($urandom_range(0, 4))
			0: return 32'hffff_ffff;
			1: return $urandom_range(0, 64);
			2: return {12'd0, 20'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(logic [31:0] a, logic [31:0] b, logic [31:0] g, logic neg);
		coef_item_t it;
		it.a = a; it.b = b; it.g = g; it.neg = neg;
		pending_q.push_back(it);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// whether the offered transaction went through at the last rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
		end
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.a_coef <= 0;
			in_ch.b_coef <= 0;
			in_ch.gamma_budget <= 0;
			in_ch.direction_negative <= 0;
			tx_gap <= 0;
		end else if (in_ch.valid && !in_taken) begin
			// hold the offered transaction
		end else if (tx_gap > 0) begin
			in_ch.valid <= 0;
			tx_gap <= tx_gap - 1;
		end else if (pending_q.size() > 0) begin
			coef_item_t it;
			it = pending_q.pop_front();
			in_ch.valid <= 1;
			in_ch.a_coef <= it.a;
			in_ch.b_coef <= it.b;
			in_ch.gamma_budget <= it.g;
			in_ch.direction_negative <= it.neg;
			tx_gap <= pick_gap();
		end else begin
			in_ch.valid <= 0;
		end
	end

	// receiver stalls
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			rx_gap <= 0;
		end else if (hold_rx) begin
			out_ch.ready <= 0;
		end else if (rx_gap > 0) begin
			out_ch.ready <= 0;
			rx_gap <= rx_gap - 1;
		end else begin
			out_ch.ready <= 1;
			rx_gap <= pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (in_ch.valid && in_ch.ready) begin
				coef_item_t it;
				it.a = in_ch.a_coef; it.b = in_ch.b_coef;
				it.g = in_ch.gamma_budget; it.neg = in_ch.direction_negative;
				angle_q.push_back(predict_angle(it));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (angle_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result angle=%0d zero=%0d", out_ch.reject_angle,
							out_ch.zero_magnitude);
					end
				end else begin
					angle_res_t e;
					e = angle_q.pop_front();
					if (e.angle !== out_ch.reject_angle || e.zero !== out_ch.zero_magnitude) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected angle=%0d zero=%0d, got angle=%0d zero=%0d",
								e.angle, e.zero, out_ch.reject_angle, out_ch.zero_magnitude);
						end
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("sinusoidal_event_reject_angle regression: fail");
				$finish;
			end
		end
	end

	initial begin
		hold_rx = 0;
		// directed: zero magnitude, extremes, each quadrant, clamping, wide budgets
		push_item(0, 0, 0, 0);
		push_item(0, 0, 32'hffff_ffff, 1);
		push_item(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1);
		push_item(32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
		push_item(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 0);
		push_item(0, 32'h8000_0000, 32'h0100_0000, 1);
		push_item(32'h0100_0000, 0, 32'h0080_0000, 0);
		push_item(32'hff00_0000, 0, 32'h0180_0000, 0);
		push_item(0, 32'h0100_0000, 32'h0100_0000, 0);
		push_item(0, 32'h0100_0000, 32'h0100_0000, 1);
		push_item(32'h0100_0000, 32'h0100_0000, 32'h0200_0000, 0);
		push_item(32'hff00_0000, 32'h0100_0000, 32'h0280_0000, 0);
		push_item(32'h0100_0000, 32'hff00_0000, 32'h0050_0000, 1);
		push_item(32'hff00_0000, 32'hff00_0000, 32'h0300_0000, 1);
		push_item(1, 0, 1, 0);
		push_item(0, 1, 2, 1);
		push_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
		push_item(3, 4, 9, 0);
		push_item(3, 4, 10, 1);
		push_item(32'h0100_0000, 0, 0, 1);
		// sender pauses until everything has drained
		wait (pending_q.size() == 0 && !in_ch.valid && angle_q.size() == 0);
		for (int i = 0; i < 60; i++) begin
			push_item(rand_coef(), rand_coef(), rand_budget(), $urandom_range(0, 1));
		end
		// long receiver hold-off while items keep coming
		@(negedge clk);
		hold_rx = 1;
		for (int i = 0; i < 250; i++) begin
			push_item(rand_coef(), rand_coef(), rand_budget(), $urandom_range(0, 1));
		end
		repeat (400) @(negedge clk);
		hold_rx = 0;
		for (int i = 0; i < 440; i++) begin
			push_item(rand_coef(), rand_coef(), rand_budget(), $urandom_range(0, 1));
		end
		wait (pending_q.size() == 0 && !in_ch.valid);
		wait (angle_q.size() == 0);
		repeat (LATENCY + 20) @(negedge clk);
		if (mismatches == 0) begin
			$display("sinusoidal_event_reject_angle regression: pass");
		end else begin
			$display("sinusoidal_event_reject_angle regression: fail");
		end
		$finish;
	end
endmodule

// File: filelist.f
design/sera_pkg.sv
design/sera_in_if.sv
design/sera_out_if.sv
design/sera_isqrt.sv
design/sera_mod.sv
design/sera_cordic.sv
design/sinusoidal_event_reject_angle.sv
tb/sv/tb_sinusoidal_event_reject_angle.sv
